@@ design/parabolic_vertex_interp_assert.svh @@
// ----------------------------------------------------------------------------
// Parabolic vertex interpolator assertion macros
// Concurrent assertion wrappers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_VERTEX_INTERP_ASSERT_SVH
`define PARABOLIC_VERTEX_INTERP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PVI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PVI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PVI_ASSERT(lbl, clk, rst_n, prop, msg)
`define PVI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/pvi_pkg.sv @@
// ----------------------------------------------------------------------------
// Parabolic vertex interpolator package
// Sizes, item types, pipeline types and shared arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pvi_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_BITS  = 16;
    localparam int OUT_BITS    = 32;
    localparam int LEN_BITS    = INDEX_BITS + 1;

    localparam int A2_W   = SAMPLE_BITS + 3;
    localparam int M_W    = SAMPLE_BITS + 1;
    localparam int MM_W   = 2 * M_W;
    localparam int NUMP_W = M_W + FRAC_BITS + 1;
    localparam int Q_W    = (NUMP_W > MM_W) ? NUMP_W : MM_W;
    localparam int D_W    = M_W + 3;
    localparam int PS_W   = ((INDEX_BITS + FRAC_BITS > Q_W) ? INDEX_BITS + FRAC_BITS : Q_W) + 2;
    localparam int SUM_W  = (PS_W > OUT_BITS + 1) ? PS_W : OUT_BITS + 1;

    typedef struct packed {
        logic        [INDEX_BITS-1:0]  center_index;
        logic        [LEN_BITS-1:0]    seq_length;
        logic signed [SAMPLE_BITS-1:0] sample_before;
        logic signed [SAMPLE_BITS-1:0] sample_at;
        logic signed [SAMPLE_BITS-1:0] sample_after;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] vertex_position;
        logic signed [OUT_BITS-1:0] vertex_value;
        logic                       saturated;
    } t_out_item;

    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [Q_W-1:0] dq;
        logic [D_W-1:0] den;
    } t_lane;

    typedef struct packed {
        logic        [INDEX_BITS-1:0]  center_index;
        logic signed [SAMPLE_BITS-1:0] sample_at;
        logic                          use_fit;
        logic                          b2_pos;
    } t_side;

    typedef struct packed {
        t_lane lp;
        t_lane lv;
        t_side sd;
    } t_stage;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] v;
        logic                       sat;
    } t_clip;

    // One restoring division step: the dividend shifts out of dq as the
    // quotient shifts in.
    function automatic t_lane lane_step(input t_lane l);
        logic [D_W:0] t;
        logic [D_W:0] diff;
        logic         ge;
        t_lane        r;
        t      = {l.rem, l.dq[Q_W-1]};
        diff   = t - {1'b0, l.den};
        ge     = (t >= {1'b0, l.den});
        r.den  = l.den;
        r.rem  = ge ? diff[D_W-1:0] : t[D_W-1:0];
        r.dq   = {l.dq[Q_W-2:0], ge};
        return r;
    endfunction

    function automatic t_stage stage_step(input t_stage s);
        t_stage r;
        r    = s;
        r.lp = lane_step(s.lp);
        r.lv = lane_step(s.lv);
        return r;
    endfunction

    function automatic t_clip sat_out(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-OUT_BITS:0] hi;
        t_clip                   c;
        hi = v[SUM_W-1:OUT_BITS-1];
        if (hi == '0 || hi == '1) begin
            c.v   = v[OUT_BITS-1:0];
            c.sat = 1'b0;
        end else begin
            c.sat = 1'b1;
            c.v   = v[SUM_W-1] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/pvi_front.sv @@
// ----------------------------------------------------------------------------
// Parabolic vertex interpolator front end
// Three stages: curvature and slope, squaring and qualification, divider
// operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module pvi_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_allow,
    input  wire logic              i_valid,
    input  wire pvi_pkg::t_in_item i_item,
    output logic                   o_valid,
    output pvi_pkg::t_stage        o_stage
);

    logic signed [pvi_pkg::A2_W-1:0] n_e0;
    logic signed [pvi_pkg::A2_W-1:0] n_e1;
    logic signed [pvi_pkg::A2_W-1:0] n_e2;
    logic signed [pvi_pkg::A2_W-1:0] n_a2;
    logic        [pvi_pkg::M_W-1:0]  n_b2;
    logic        [pvi_pkg::M_W-1:0]  n_m;
    logic                            n_b2pos;
    logic                            n_inner;

    logic                               r_a_vld;
    logic [pvi_pkg::INDEX_BITS-1:0]     r_a_idx;
    logic signed [pvi_pkg::SAMPLE_BITS-1:0] r_a_s1;
    logic                               r_a_inner;
    logic                               r_a_allow;
    logic signed [pvi_pkg::A2_W-1:0]    r_a_a2;
    logic [pvi_pkg::M_W-1:0]            r_a_m;
    logic                               r_a_b2pos;

    logic                        n_a2pos;
    logic [pvi_pkg::M_W-1:0]     n_ua;
    logic                        n_okshift;
    logic                        n_use;
    logic [pvi_pkg::MM_W-1:0]    n_mm;
    logic [pvi_pkg::Q_W-1:0]     n_nump;

    logic                               r_b_vld;
    logic [pvi_pkg::INDEX_BITS-1:0]     r_b_idx;
    logic signed [pvi_pkg::SAMPLE_BITS-1:0] r_b_s1;
    logic                               r_b_use;
    logic                               r_b_b2pos;
    logic [pvi_pkg::M_W-1:0]            r_b_ua;
    logic [pvi_pkg::MM_W-1:0]           r_b_mm;
    logic [pvi_pkg::Q_W-1:0]            r_b_nump;

    pvi_pkg::t_stage n_c_stage;
    logic            r_c_vld;
    pvi_pkg::t_stage r_c_stage;

    always_comb begin
        n_e0 = {{(pvi_pkg::A2_W-pvi_pkg::SAMPLE_BITS){i_item.sample_before[pvi_pkg::SAMPLE_BITS-1]}},
                i_item.sample_before};
        n_e1 = {{(pvi_pkg::A2_W-pvi_pkg::SAMPLE_BITS){i_item.sample_at[pvi_pkg::SAMPLE_BITS-1]}},
                i_item.sample_at};
        n_e2 = {{(pvi_pkg::A2_W-pvi_pkg::SAMPLE_BITS){i_item.sample_after[pvi_pkg::SAMPLE_BITS-1]}},
                i_item.sample_after};
        n_a2    = n_e0 + n_e2 - (n_e1 <<< 1);
        n_b2    = n_e2[pvi_pkg::M_W-1:0] - n_e0[pvi_pkg::M_W-1:0];
        n_m     = n_b2[pvi_pkg::M_W-1] ? (~n_b2 + 1'b1) : n_b2;
        n_b2pos = !n_b2[pvi_pkg::M_W-1] && (n_b2 != '0);
        n_inner = (i_item.center_index != '0) &&
                  ((pvi_pkg::LEN_BITS'(i_item.center_index) + pvi_pkg::LEN_BITS'(1))
                   < i_item.seq_length);
    end

    always_comb begin
        n_a2pos   = !r_a_a2[pvi_pkg::A2_W-1] && (r_a_a2 != '0);
        n_ua      = r_a_a2[pvi_pkg::M_W-1:0];
        n_okshift = r_a_allow || ({1'b0, r_a_m} <= {n_ua, 1'b0});
        n_use     = r_a_inner && n_a2pos && n_okshift;
        n_mm      = pvi_pkg::MM_W'(r_a_m) * pvi_pkg::MM_W'(r_a_m);
        n_nump    = (pvi_pkg::Q_W'(r_a_m) << pvi_pkg::FRAC_BITS) + pvi_pkg::Q_W'(n_ua);
    end

    always_comb begin
        n_c_stage.lp.rem          = '0;
        n_c_stage.lp.dq           = r_b_nump;
        n_c_stage.lp.den          = pvi_pkg::D_W'({r_b_ua, 1'b0});
        n_c_stage.lv.rem          = '0;
        n_c_stage.lv.dq           = pvi_pkg::Q_W'(r_b_mm) + pvi_pkg::Q_W'({r_b_ua, 2'b00});
        n_c_stage.lv.den          = {r_b_ua, 3'b000};
        n_c_stage.sd.center_index = r_b_idx;
        n_c_stage.sd.sample_at    = r_b_s1;
        n_c_stage.sd.use_fit      = r_b_use;
        n_c_stage.sd.b2_pos       = r_b_b2pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_idx   <= i_item.center_index;
            r_a_s1    <= i_item.sample_at;
            r_a_inner <= n_inner;
            r_a_allow <= i_allow;
            r_a_a2    <= n_a2;
            r_a_m     <= n_m;
            r_a_b2pos <= n_b2pos;
            r_b_idx   <= r_a_idx;
            r_b_s1    <= r_a_s1;
            r_b_use   <= n_use;
            r_b_b2pos <= r_a_b2pos;
            r_b_ua    <= n_ua;
            r_b_mm    <= n_mm;
            r_b_nump  <= n_nump;
            r_c_stage <= n_c_stage;
        end
    end

    assign o_valid = r_c_vld;
    assign o_stage = r_c_stage;

endmodule

`default_nettype wire

@@ design/pvi_div.sv @@
// ----------------------------------------------------------------------------
// Parabolic vertex interpolator divider
// Two restoring dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pvi_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire pvi_pkg::t_stage i_stage,
    output logic                 o_valid,
    output pvi_pkg::t_stage      o_stage
);

    logic [pvi_pkg::Q_W-1:0] r_vld;
    pvi_pkg::t_stage         r_st [pvi_pkg::Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[pvi_pkg::Q_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= pvi_pkg::stage_step(i_stage);
            for (int k = 1; k < pvi_pkg::Q_W; k++) begin
                r_st[k] <= pvi_pkg::stage_step(r_st[k-1]);
            end
        end
    end

    assign o_valid = r_vld[pvi_pkg::Q_W-1];
    assign o_stage = r_st[pvi_pkg::Q_W-1];

endmodule

`default_nettype wire

@@ design/pvi_back.sv @@
// ----------------------------------------------------------------------------
// Parabolic vertex interpolator back end
// Applies the shift and the drop, then clips both results to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pvi_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire pvi_pkg::t_stage i_stage,
    output logic                 o_valid,
    output pvi_pkg::t_out_item   o_item
);

    logic signed [pvi_pkg::SUM_W-1:0] n_base;
    logic signed [pvi_pkg::SUM_W-1:0] n_mag;
    logic signed [pvi_pkg::SUM_W-1:0] n_pos;
    logic signed [pvi_pkg::SUM_W-1:0] n_s1;
    logic signed [pvi_pkg::SUM_W-1:0] n_drop;
    logic signed [pvi_pkg::SUM_W-1:0] n_val;

    logic                             r_f_vld;
    logic signed [pvi_pkg::SUM_W-1:0] r_pos;
    logic signed [pvi_pkg::SUM_W-1:0] r_val;

    pvi_pkg::t_clip     n_cp;
    pvi_pkg::t_clip     n_cv;
    pvi_pkg::t_out_item n_res;
    logic               r_o_vld;
    pvi_pkg::t_out_item r_res;

    always_comb begin
        n_base = pvi_pkg::SUM_W'({i_stage.sd.center_index, {pvi_pkg::FRAC_BITS{1'b0}}});
        n_mag  = i_stage.sd.use_fit ? pvi_pkg::SUM_W'(i_stage.lp.dq) : '0;
        n_pos  = i_stage.sd.b2_pos ? (n_base - n_mag) : (n_base + n_mag);
        n_s1   = {{(pvi_pkg::SUM_W-pvi_pkg::SAMPLE_BITS){i_stage.sd.sample_at[pvi_pkg::SAMPLE_BITS-1]}},
                  i_stage.sd.sample_at};
        n_drop = i_stage.sd.use_fit ? pvi_pkg::SUM_W'(i_stage.lv.dq) : '0;
        n_val  = n_s1 - n_drop;
    end

    always_comb begin
        n_cp                  = pvi_pkg::sat_out(r_pos);
        n_cv                  = pvi_pkg::sat_out(r_val);
        n_res.vertex_position = n_cp.v;
        n_res.vertex_value    = n_cv.v;
        n_res.saturated       = n_cp.sat | n_cv.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= i_valid;
            r_o_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= n_pos;
            r_val <= n_val;
            r_res <= n_res;
        end
    end

    assign o_valid = r_o_vld;
    assign o_item  = r_res;

endmodule

`default_nettype wire

@@ design/parabolic_vertex_interp.sv @@
// ----------------------------------------------------------------------------
// Parabolic vertex interpolator
// Fits a parabola through three samples around a minimum and returns the
// refined vertex position and the vertex value, both saturated.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_in_item  (t_in_item)
//   output    o_out_valid / i_out_ready  o_out_item (t_out_item)
//   config    i_cfg_we                   i_cfg_wdata (allow_large_shift)
//
// One item enters per clock cycle while the skid register is empty; with the
// default sizes the bit-per-stage dividers have 50 stages.
// Reset clears the pipeline valid bits, the output and skid valid flags and
// the mode register.
// A stalled output fills the skid register, after which the whole pipeline
// holds until the skid register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module parabolic_vertex_interp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pvi_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pvi_pkg::t_out_item      o_out_item
);

`include "parabolic_vertex_interp_assert.svh"

    logic               w_en;
    logic               w_front_valid;
    pvi_pkg::t_stage    w_front_stage;
    logic               w_div_valid;
    pvi_pkg::t_stage    w_div_stage;
    logic               w_res_valid;
    pvi_pkg::t_out_item w_res_item;

    logic               r_allow;
    logic               r_out_valid;
    pvi_pkg::t_out_item r_out_item;
    logic               r_skid_valid;
    pvi_pkg::t_out_item r_skid_item;

    assign w_en = !r_skid_valid;

    pvi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_allow (r_allow),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (w_front_valid),
        .o_stage (w_front_stage)
    );

    pvi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_stage (w_front_stage),
        .o_valid (w_div_valid),
        .o_stage (w_div_stage)
    );

    pvi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid),
        .i_stage (w_div_stage),
        .o_valid (w_res_valid),
        .o_item  (w_res_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_allow <= i_cfg_wdata;
            end
            if (!r_out_valid || i_out_ready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_res_valid && w_en;
                end
            end else if (w_res_valid && w_en) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else begin
                r_out_item <= w_res_item;
            end
        end else if (w_res_valid && w_en) begin
            r_skid_item <= w_res_item;
        end
    end

    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PVI_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "reset left an item pending")
    `PVI_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid item held while output register is empty")
    `PVI_ASSERT(a_skid_drains, i_clk, i_rst_n, r_skid_valid |=> (r_skid_valid != $past(i_out_ready)), "skid register did not drain or hold as expected")
    `PVI_ASSERT(a_no_drop, i_clk, i_rst_n, w_res_valid && w_en && r_out_valid && !i_out_ready |=> r_skid_valid, "arriving item was not captured by the skid register")

endmodule

`default_nettype wire
